// ===== src/ampm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the adduct mass peak matcher.
package ampm_pkg;

    // Field widths of the request and response beats.
    localparam int OP_W          = 1;
    localparam int SLOT_FIELD_W  = 6;
    localparam int MASS_W        = 40;
    localparam int CHARGE_W      = 4;
    localparam int MULT_W        = 3;
    localparam int ADDUCT_ID_W   = 16;
    localparam int COMPOUND_ID_W = 20;
    localparam int EXP_W         = 43;

    // Arithmetic widths.
    localparam int NUM_W          = 44;
    localparam int TOL_W          = 32;
    localparam int PRODUCT_W      = 2 * TOL_W;
    localparam int BIG_HI_W       = EXP_W - TOL_W;
    localparam int DIV_DIGIT_BITS = 4;
    localparam int DIV_STEPS      = NUM_W / DIV_DIGIT_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int PEAKS_W     = 7;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAKS     = 1'b1;
    localparam logic [TOL_W-1:0]       TOL_RESET     = 32'd42950;

    // Operation codes of a request beat.
    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

    // Default depth of the peak table.
    localparam int PEAK_SLOTS_DEFAULT = 64;

    // One request beat.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [SLOT_FIELD_W-1:0]  load_slot;
        logic [MASS_W-1:0]        peak_mass;
        logic signed [MASS_W-1:0] adduct_shift;
        logic [CHARGE_W-1:0]      adduct_charge_abs;
        logic [MULT_W-1:0]        adduct_multiplicity;
        logic [MASS_W-1:0]        compound_mono_mass;
        logic [ADDUCT_ID_W-1:0]   adduct_id;
        logic [COMPOUND_ID_W-1:0] compound_id;
    } ampm_req_t;

    // One response beat.
    typedef struct packed {
        logic [SLOT_FIELD_W-1:0]  match_slot;
        logic [ADDUCT_ID_W-1:0]   match_adduct;
        logic [COMPOUND_ID_W-1:0] match_compound;
        logic [EXP_W-1:0]         expected_mz;
        logic                     last_match;
    } ampm_rsp_t;

endpackage

// ===== src/adduct_mass_peak_matcher_top.sv =====
`timescale 1ns / 1ps
// Adduct mass peak matcher: peak table, expected mass divider and match scan.
//
// A load beat writes one peak slot. A query beat computes the expected mass
// (multiplicity * compound mass + shift) / charge with a single divider that
// retires four quotient bits per cycle, then reads the peak table one slot per
// cycle, while the response side does not stall, through its single read port
// and sends each slot read through a compare pipeline built around two tolerance
// multipliers. A query keeps the request side stalled through its divide, scan
// and pipeline drain (the divide alone when no slot is in use), and longer while
// the response side stalls; a load or a query with a negative numerator causes no
// stall. The last match of a query carries last_match; a query with no match or a
// negative numerator sends no response beat. Peak slots must be loaded before a
// query reads them.
module adduct_mass_peak_matcher_top
    import ampm_pkg::*;
#(
    parameter int PEAK_SLOTS = PEAK_SLOTS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  ampm_req_t              req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output ampm_rsp_t              rsp,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;
    localparam int CNT_W  = $clog2(PEAK_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // Restoring division step: four quotient bits per call.
    function automatic logic [CHARGE_W+NUM_W-1:0] div_digit(
        input logic [CHARGE_W-1:0] r_in,
        input logic [NUM_W-1:0]    q_in,
        input logic [CHARGE_W-1:0] d
    );
        logic [CHARGE_W:0]   t;
        logic [CHARGE_W-1:0] r;
        logic [NUM_W-1:0]    q;
        r = r_in;
        q = q_in;
        for (int k = 0; k < DIV_DIGIT_BITS; k++)
        begin
            t = {r, q[NUM_W-1]};
            q = {q[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t    = t - {1'b0, d};
                q[0] = 1'b1;
            end
            r = t[CHARGE_W-1:0];
        end
        return {r, q};
    endfunction

    // Registers.
    state_t                   state_reg, state_next;
    logic [TOL_W-1:0]         tol_reg, tol_next;
    logic [PEAKS_W-1:0]       peaks_reg, peaks_next;
    logic [NUM_W-1:0]         quot_reg, quot_next;
    logic [CHARGE_W-1:0]      rem_reg, rem_next;
    logic [CHARGE_W-1:0]      charge_reg, charge_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [ADDUCT_ID_W-1:0]   aid_reg, aid_next;
    logic [COMPOUND_ID_W-1:0] cid_reg, cid_next;
    logic [CNT_W-1:0]         issue_cnt_reg, issue_cnt_next;

    logic                     s1_valid_reg, s1_valid_next;
    logic [SLOT_W-1:0]        s1_slot_reg, s1_slot_next;
    logic [MASS_W-1:0]        peak_rd_reg;

    logic                     s2_valid_reg, s2_valid_next;
    logic [SLOT_W-1:0]        s2_slot_reg, s2_slot_next;
    logic [EXP_W-1:0]         s2_diff_reg, s2_diff_next;
    logic [EXP_W-1:0]         s2_big_reg, s2_big_next;

    logic                     s3_valid_reg, s3_valid_next;
    logic [SLOT_W-1:0]        s3_slot_reg, s3_slot_next;
    logic [EXP_W-1:0]         s3_diff_reg, s3_diff_next;
    logic [BIG_HI_W-1:0]      s3_big_hi_reg, s3_big_hi_next;
    logic [PRODUCT_W-1:0]     s3_lo_reg, s3_lo_next;

    logic                     s4_valid_reg, s4_valid_next;
    logic [SLOT_W-1:0]        s4_slot_reg, s4_slot_next;
    logic [EXP_W-1:0]         s4_diff_reg, s4_diff_next;
    logic [TOL_W-1:0]         s4_lo_top_reg, s4_lo_top_next;
    logic [EXP_W-1:0]         s4_hi_reg, s4_hi_next;

    logic                     pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]        pend_slot_reg, pend_slot_next;

    logic                     rsp_valid_reg, rsp_valid_next;
    ampm_rsp_t                rsp_reg, rsp_next;

    logic [MASS_W-1:0]        peak_mem [PEAK_SLOTS];

    // Combinational helpers.
    logic                     advance;
    logic                     accept;
    logic                     load_wr;
    logic                     issue;
    logic                     pipe_empty;
    logic                     hit;
    logic [CNT_W-1:0]         scan_limit;
    logic [EXP_W-1:0]         prod;
    logic signed [NUM_W:0]    num;
    logic [EXP_W-1:0]         peak_ext;
    logic [NUM_W-1:0]         thresh;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Handshake and pipeline advance.
    assign advance    = !rsp_valid_reg || !rsp_stall;
    assign accept     = req_valid && (state_reg == ST_IDLE);
    assign load_wr    = accept && (req.op == OP_LOAD)
                        && (PEAKS_W'(req.load_slot) < PEAKS_W'(PEAK_SLOTS));
    assign issue      = advance && (state_reg == ST_SCAN);
    assign pipe_empty = !(s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg);

    // Number of slots a query scans, saturated to the table depth.
    assign scan_limit = (peaks_reg > PEAKS_W'(PEAK_SLOTS)) ? CNT_W'(PEAK_SLOTS)
                                                           : CNT_W'(peaks_reg);

    // Numerator: small shift-add product plus the sign-extended shift.
    assign prod = (req.adduct_multiplicity[0] ? EXP_W'(req.compound_mono_mass) : '0)
                + (req.adduct_multiplicity[1] ? EXP_W'(req.compound_mono_mass) << 1 : '0)
                + (req.adduct_multiplicity[2] ? EXP_W'(req.compound_mono_mass) << 2 : '0);
    assign num  = $signed({2'b00, prod})
                + $signed({{(NUM_W + 1 - MASS_W){req.adduct_shift[MASS_W-1]}},
                           req.adduct_shift});

    // Tolerance threshold and match decision at the end of the pipeline.
    assign peak_ext = EXP_W'(peak_rd_reg);
    assign thresh   = NUM_W'(s4_hi_reg) + NUM_W'(s4_lo_top_reg);
    assign hit      = s4_valid_reg && (NUM_W'(s4_diff_reg) <= thresh);

    // Next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        tol_next        = tol_reg;
        peaks_next      = peaks_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        charge_next     = charge_reg;
        div_cnt_next    = div_cnt_reg;
        aid_next        = aid_reg;
        cid_next        = cid_reg;
        issue_cnt_next  = issue_cnt_reg;
        s1_valid_next   = s1_valid_reg;
        s1_slot_next    = s1_slot_reg;
        s2_valid_next   = s2_valid_reg;
        s2_slot_next    = s2_slot_reg;
        s2_diff_next    = s2_diff_reg;
        s2_big_next     = s2_big_reg;
        s3_valid_next   = s3_valid_reg;
        s3_slot_next    = s3_slot_reg;
        s3_diff_next    = s3_diff_reg;
        s3_big_hi_next  = s3_big_hi_reg;
        s3_lo_next      = s3_lo_reg;
        s4_valid_next   = s4_valid_reg;
        s4_slot_next    = s4_slot_reg;
        s4_diff_next    = s4_diff_reg;
        s4_lo_top_next  = s4_lo_top_reg;
        s4_hi_next      = s4_hi_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        // Configuration writes.
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TOLERANCE: tol_next   = cfg_data[TOL_W-1:0];
                CFG_PEAKS:     peaks_next = cfg_data[PEAKS_W-1:0];
                default:       ;
            endcase
        end

        // Sequencer.
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.op == OP_QUERY) && !num[NUM_W])
                begin
                    quot_next    = num[NUM_W-1:0];
                    rem_next     = '0;
                    charge_next  = (req.adduct_charge_abs == '0) ? CHARGE_W'(1)
                                                                 : req.adduct_charge_abs;
                    aid_next     = req.adduct_id;
                    cid_next     = req.compound_id;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                {rem_next, quot_next} = div_digit(rem_reg, quot_reg, charge_reg);
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    issue_cnt_next = '0;
                    state_next     = (scan_limit == '0) ? ST_IDLE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    if ((issue_cnt_reg + 1'b1) == scan_limit)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (advance && pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Compare pipeline, pending match and response register move together.
        if (advance)
        begin
            s1_valid_next = issue;
            s1_slot_next  = issue_cnt_reg[SLOT_W-1:0];

            s2_valid_next = s1_valid_reg;
            s2_slot_next  = s1_slot_reg;
            if (peak_ext > quot_reg[EXP_W-1:0])
            begin
                s2_diff_next = peak_ext - quot_reg[EXP_W-1:0];
                s2_big_next  = peak_ext;
            end
            else
            begin
                s2_diff_next = quot_reg[EXP_W-1:0] - peak_ext;
                s2_big_next  = quot_reg[EXP_W-1:0];
            end

            s3_valid_next  = s2_valid_reg;
            s3_slot_next   = s2_slot_reg;
            s3_diff_next   = s2_diff_reg;
            s3_big_hi_next = s2_big_reg[EXP_W-1:TOL_W];
            s3_lo_next     = PRODUCT_W'(s2_big_reg[TOL_W-1:0]) * PRODUCT_W'(tol_reg);

            s4_valid_next  = s3_valid_reg;
            s4_slot_next   = s3_slot_reg;
            s4_diff_next   = s3_diff_reg;
            s4_lo_top_next = s3_lo_reg[PRODUCT_W-1:TOL_W];
            s4_hi_next     = EXP_W'(s3_big_hi_reg) * EXP_W'(tol_reg);

            // A match is held back one beat so the final one can be flagged.
            rsp_valid_next = 1'b0;
            rsp_next.match_adduct   = aid_reg;
            rsp_next.match_compound = cid_reg;
            rsp_next.expected_mz    = quot_reg[EXP_W-1:0];
            rsp_next.match_slot     = SLOT_FIELD_W'(pend_slot_reg);
            if (hit)
            begin
                rsp_next.last_match = 1'b0;
                rsp_valid_next      = pend_valid_reg;
                pend_valid_next     = 1'b1;
                pend_slot_next      = s4_slot_reg;
            end
            else if ((state_reg == ST_DRAIN) && pipe_empty && pend_valid_reg)
            begin
                rsp_next.last_match = 1'b1;
                rsp_valid_next      = 1'b1;
                pend_valid_next     = 1'b0;
            end
            else
            begin
                rsp_next.last_match = 1'b0;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tol_reg        <= TOL_RESET;
            peaks_reg      <= '0;
            quot_reg       <= '0;
            rem_reg        <= '0;
            charge_reg     <= '0;
            div_cnt_reg    <= '0;
            aid_reg        <= '0;
            cid_reg        <= '0;
            issue_cnt_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            s1_slot_reg    <= '0;
            s2_valid_reg   <= 1'b0;
            s2_slot_reg    <= '0;
            s2_diff_reg    <= '0;
            s2_big_reg     <= '0;
            s3_valid_reg   <= 1'b0;
            s3_slot_reg    <= '0;
            s3_diff_reg    <= '0;
            s3_big_hi_reg  <= '0;
            s3_lo_reg      <= '0;
            s4_valid_reg   <= 1'b0;
            s4_slot_reg    <= '0;
            s4_diff_reg    <= '0;
            s4_lo_top_reg  <= '0;
            s4_hi_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_slot_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            tol_reg        <= tol_next;
            peaks_reg      <= peaks_next;
            quot_reg       <= quot_next;
            rem_reg        <= rem_next;
            charge_reg     <= charge_next;
            div_cnt_reg    <= div_cnt_next;
            aid_reg        <= aid_next;
            cid_reg        <= cid_next;
            issue_cnt_reg  <= issue_cnt_next;
            s1_valid_reg   <= s1_valid_next;
            s1_slot_reg    <= s1_slot_next;
            s2_valid_reg   <= s2_valid_next;
            s2_slot_reg    <= s2_slot_next;
            s2_diff_reg    <= s2_diff_next;
            s2_big_reg     <= s2_big_next;
            s3_valid_reg   <= s3_valid_next;
            s3_slot_reg    <= s3_slot_next;
            s3_diff_reg    <= s3_diff_next;
            s3_big_hi_reg  <= s3_big_hi_next;
            s3_lo_reg      <= s3_lo_next;
            s4_valid_reg   <= s4_valid_next;
            s4_slot_reg    <= s4_slot_next;
            s4_diff_reg    <= s4_diff_next;
            s4_lo_top_reg  <= s4_lo_top_next;
            s4_hi_reg      <= s4_hi_next;
            pend_valid_reg <= pend_valid_next;
            pend_slot_reg  <= pend_slot_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    // Peak table: one write port for loads, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            peak_mem[req.load_slot[SLOT_W-1:0]] <= req.peak_mass;
        end
        if (issue)
        begin
            peak_rd_reg <= peak_mem[issue_cnt_reg[SLOT_W-1:0]];
        end
    end

endmodule

// ===== dv/adduct_mass_peak_matcher_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the adduct mass peak matcher, with a built-in match predictor.
module adduct_mass_peak_matcher_top_test
    import ampm_pkg::*;
();

    localparam int      REQ_W        = $bits(ampm_req_t);
    localparam longint  MASS_MAX     = (longint'(1) << MASS_W) - 1;
    // Covers a query that scans up to 64 slots, plus its divide and compare.
    localparam int      DRAIN_CYCLES = 160;
    localparam longint  TIMEOUT_NS   = 4_000_000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    ampm_req_t              req       = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    ampm_rsp_t              rsp;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor state: a copy of the peak table and of both registers.
    logic [MASS_W-1:0]  peak_copy [0:PEAK_SLOTS_DEFAULT-1];
    logic [TOL_W-1:0]   tol_setting   = TOL_RESET;
    logic [PEAKS_W-1:0] peaks_setting = '0;

    ampm_rsp_t pending_matches [$];
    ampm_rsp_t want_beat;
    int        mismatch_count = 0;
    int        idle_pct       = 12;

    adduct_mass_peak_matcher_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // The response side stalls at random.
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < idle_pct);
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Loads update the table; queries compute the expected mass and the matching slots.
    function automatic void predict_matches(input ampm_req_t beat);
        logic [47:0]        product;
        logic [47:0]        numer;
        logic [47:0]        quot;
        logic [CHARGE_W-1:0] divisor;
        logic [EXP_W-1:0]   exp_mz;
        logic [NUM_W-1:0]   peak_v;
        logic [NUM_W-1:0]   exp_v;
        logic [NUM_W-1:0]   diff;
        logic [NUM_W-1:0]   big;
        logic [79:0]        scaled;
        int                 span;
        ampm_rsp_t          hit;
        ampm_rsp_t          hits [$];
        if (beat.op == OP_LOAD)
        begin
            peak_copy[beat.load_slot] = beat.peak_mass;
            return;
        end
        product = 48'(beat.adduct_multiplicity) * 48'(beat.compound_mono_mass);
        numer   = product + {{8{beat.adduct_shift[MASS_W-1]}}, beat.adduct_shift};
        // A negative numerator matches nothing.
        if (numer[47])
        begin
            return;
        end
        divisor = (beat.adduct_charge_abs == '0) ? CHARGE_W'(1) : beat.adduct_charge_abs;
        quot    = numer / 48'(divisor);
        exp_mz  = quot[EXP_W-1:0];
        span    = (peaks_setting > PEAK_SLOTS_DEFAULT) ? PEAK_SLOTS_DEFAULT : int'(peaks_setting);
        exp_v   = NUM_W'(exp_mz);
        for (int i = 0; i < span; i++)
        begin
            peak_v = NUM_W'(peak_copy[i]);
            diff   = (peak_v > exp_v) ? peak_v - exp_v : exp_v - peak_v;
            big    = (peak_v > exp_v) ? peak_v : exp_v;
            scaled = 80'(big) * 80'(tol_setting);
            if (80'(diff) <= (scaled >> 32))
            begin
                hit.match_slot     = SLOT_FIELD_W'(i);
                hit.match_adduct   = beat.adduct_id;
                hit.match_compound = beat.compound_id;
                hit.expected_mz    = exp_mz;
                hit.last_match     = 1'b0;
                hits.push_back(hit);
            end
        end
        if (hits.size() > 0)
        begin
            hits[hits.size()-1].last_match = 1'b1;
        end
        foreach (hits[k])
        begin
            pending_matches.push_back(hits[k]);
        end
    endfunction

    // Compare every accepted response beat with the oldest expected match.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_matches.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat, slot %0d", rsp.match_slot));
            end
            else
            begin
                want_beat = pending_matches.pop_front();
                if (rsp.match_slot !== want_beat.match_slot)
                    report_mismatch($sformatf("match_slot %0d, want %0d",
                                              rsp.match_slot, want_beat.match_slot));
                if (rsp.match_adduct !== want_beat.match_adduct)
                    report_mismatch($sformatf("match_adduct %0h, want %0h",
                                              rsp.match_adduct, want_beat.match_adduct));
                if (rsp.match_compound !== want_beat.match_compound)
                    report_mismatch($sformatf("match_compound %0h, want %0h",
                                              rsp.match_compound, want_beat.match_compound));
                if (rsp.expected_mz !== want_beat.expected_mz)
                    report_mismatch($sformatf("expected_mz %0h, want %0h",
                                              rsp.expected_mz, want_beat.expected_mz));
                if (rsp.last_match !== want_beat.last_match)
                    report_mismatch($sformatf("last_match %0b, want %0b",
                                              rsp.last_match, want_beat.last_match));
            end
        end
    end

    function automatic ampm_req_t random_req();
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return ampm_req_t'(raw[REQ_W-1:0]);
    endfunction

    // Load beat; the query fields carry random bits that the block must ignore.
    function automatic ampm_req_t load_beat(input logic [SLOT_FIELD_W-1:0] slot,
                                            input logic [MASS_W-1:0] mass);
        ampm_req_t beat;
        beat           = random_req();
        beat.op        = OP_LOAD;
        beat.load_slot = slot;
        beat.peak_mass = mass;
        return beat;
    endfunction

    function automatic ampm_req_t query_beat(input logic [MULT_W-1:0] mult,
                                             input logic [CHARGE_W-1:0] charge,
                                             input logic [MASS_W-1:0] comp,
                                             input logic [MASS_W-1:0] shift,
                                             input logic [ADDUCT_ID_W-1:0] aid,
                                             input logic [COMPOUND_ID_W-1:0] cid);
        ampm_req_t beat;
        beat                     = random_req();
        beat.op                  = OP_QUERY;
        beat.adduct_multiplicity = mult;
        beat.adduct_charge_abs   = charge;
        beat.compound_mono_mass  = comp;
        beat.adduct_shift        = shift;
        beat.adduct_id           = aid;
        beat.compound_id         = cid;
        return beat;
    endfunction

    // Send one request beat after a random gap and predict it once accepted.
    task automatic send_beat(input ampm_req_t beat);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        predict_matches(beat);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (index == CFG_TOLERANCE)
            tol_setting = data;
        else
            peaks_setting = data[PEAKS_W-1:0];
        @(posedge clk);
    endtask

    // Wait for every expected match, then let a query without matches finish its scan.
    task automatic wait_quiet();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Hand-picked items around a 1000 Da peak, tolerance edges and field extremes.
    task automatic test_directed();
        logic [MASS_W-1:0] p0;
        logic [MASS_W-1:0] win;
        p0  = 40'd16777216000;
        win = MASS_W'((longint'(p0) * 42950) >>> 32);
        // No slots in use yet, so nothing can match.
        send_beat(query_beat(3'd1, 4'd1, p0, '0, '1, '1));
        send_beat(load_beat(6'd0, p0));
        send_beat(load_beat(6'd1, p0 + win));
        send_beat(load_beat(6'd2, p0 + win + 40'd2));
        send_beat(load_beat(6'd3, '1));
        wait_quiet();
        write_reg(CFG_PEAKS, 32'd4);
        send_beat(query_beat(3'd1, 4'd1, p0, '0, '0, '0));
        send_beat(query_beat(3'd2, 4'd2, p0, '0, 16'd1, 20'd1));
        // Zero charge divides by one.
        send_beat(query_beat(3'd1, 4'd0, p0, '0, 16'h1234, 20'h54321));
        // Zero multiplicity leaves the shift alone over the charge.
        send_beat(query_beat(3'd0, 4'd3, MASS_W'({$urandom, $urandom}), p0 * 40'd3, '1, '0));
        // Negative numerators, then large and small positive ones.
        send_beat(query_beat(3'd0, 4'd1, MASS_W'($urandom), '1, '0, '1));
        send_beat(query_beat(3'd1, 4'd1, '0, 40'h80_0000_0000, 16'hAAAA, 20'h55555));
        send_beat(query_beat(3'd7, 4'd1, '1, 40'h7F_FFFF_FFFF, '1, '1));
        send_beat(query_beat(3'd7, 4'd15, '1, '1, 16'h8000, 20'h80000));
        send_beat(query_beat(3'd1, 4'd1, '1, '0, 16'h00FF, 20'h0FFFF));
        send_beat(query_beat(3'd1, 4'd1, 40'd5, '0, 16'h0F0F, 20'hF0F0F));
        wait_quiet();
        write_reg(CFG_TOLERANCE, '1);
        send_beat(query_beat(3'd1, 4'd1, p0, '0, 16'd2, 20'd2));
        send_beat(query_beat(3'd1, 4'd1, 40'd1, '0, 16'd3, 20'd3));
        wait_quiet();
        write_reg(CFG_TOLERANCE, '0);
        send_beat(query_beat(3'd1, 4'd1, p0, '0, 16'd4, 20'd4));
        send_beat(query_beat(3'd1, 4'd1, p0 + win, '0, 16'd5, 20'd5));
        wait_quiet();
    endtask

    // Fill every slot; about a third sit close to their neighbor so queries hit several.
    task automatic test_table_fill();
        longint mass;
        for (int s = 0; s < PEAK_SLOTS_DEFAULT; s++)
        begin
            if (s > 0 && $urandom_range(2) == 0)
                mass = longint'(peak_copy[s-1]) + longint'($urandom_range(4000)) - 2000;
            else
                mass = longint'(MASS_W'({$urandom, $urandom}) >> $urandom_range(24));
            send_beat(load_beat(SLOT_FIELD_W'(s), MASS_W'(mass)));
        end
        wait_quiet();
    endtask

    // Mostly queries aimed at a stored peak, plus reloads and fully random beats.
    task automatic run_random_phase(input logic [TOL_W-1:0] tol,
                                    input logic [PEAKS_W-1:0] peaks,
                                    input int n_items, input int idle);
        int                  kind;
        int                  slot;
        int                  span;
        longint              p;
        longint              target;
        longint              comp_l;
        longint              shift_l;
        longint              win;
        longint              jitter;
        logic [MULT_W-1:0]   mult;
        logic [CHARGE_W-1:0] charge;
        ampm_req_t           beat;
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_PEAKS, CFG_DATA_W'(peaks));
        idle_pct = idle;
        span = (peaks > PEAK_SLOTS_DEFAULT) ? PEAK_SLOTS_DEFAULT : int'(peaks);
        for (int n = 0; n < n_items; n++)
        begin
            kind = $urandom_range(99);
            if (kind < 25)
            begin
                slot = $urandom_range(63);
                if ($urandom_range(1) == 1)
                    p = longint'(peak_copy[$urandom_range(63)])
                        + longint'($urandom_range(4000)) - 2000;
                else
                    p = longint'(MASS_W'({$urandom, $urandom}) >> $urandom_range(24));
                beat = load_beat(SLOT_FIELD_W'(slot), MASS_W'(p));
            end
            else if (kind < 37)
            begin
                beat = random_req();
            end
            else
            begin
                // Pick the compound and shift so the expected mass lands on a stored peak,
                // then jitter it across the tolerance window.
                slot   = (span == 0) ? $urandom_range(63) : $urandom_range(span - 1);
                p      = longint'(peak_copy[slot]);
                mult   = ($urandom_range(9) == 0) ? '0 : MULT_W'($urandom_range(7, 1));
                charge = CHARGE_W'($urandom_range(15, 1));
                target = p * longint'(charge);
                if (mult == '0)
                    comp_l = longint'($urandom);
                else
                    comp_l = target / longint'(mult) - longint'($urandom_range(3));
                if (comp_l < 0)
                    comp_l = 0;
                if (comp_l > MASS_MAX)
                    comp_l = MASS_MAX;
                win = ((p >>> 8) * (longint'(tol) >>> 8)) >>> 16;
                if (win > (longint'(1) << 28))
                    win = longint'(1) << 28;
                if ($urandom_range(3) == 0)
                    jitter = 0;
                else
                    jitter = longint'($urandom_range(32'(2 * win + 4))) - (win + 2);
                shift_l = target - longint'(mult) * comp_l
                          + longint'($urandom_range(32'(charge) - 1))
                          + jitter * longint'(charge);
                beat = query_beat(mult, charge, MASS_W'(comp_l), MASS_W'(shift_l),
                                  ADDUCT_ID_W'($urandom), COMPOUND_ID_W'($urandom));
            end
            send_beat(beat);
        end
        wait_quiet();
    endtask

    task automatic test_random_default();
        run_random_phase(TOL_RESET, 7'd64, 40, 12);
    endtask

    // Zero tolerance: only exact expected masses match.
    task automatic test_tight_tolerance();
        run_random_phase('0, 7'd1, 40, 12);
        run_random_phase('0, 7'd64, 40, 12);
    endtask

    // Widest tolerance and a slot count above the table depth, which saturates.
    task automatic test_wide_tolerance();
        run_random_phase('1, 7'd127, 40, 12);
    endtask

    task automatic test_random_settings();
        for (int r = 0; r < 2; r++)
        begin
            run_random_phase($urandom >> $urandom_range(31), PEAKS_W'($urandom_range(64)),
                             40, 12);
        end
    endtask

    // A long stretch with neither side idling.
    task automatic test_no_idle_stretch();
        run_random_phase(32'h0010_0000, 7'd64, 80, 0);
    endtask

    task automatic test_zero_peaks();
        run_random_phase(TOL_RESET, 7'd0, 15, 12);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_fill();
        test_random_default();
        test_tight_tolerance();
        test_wide_tolerance();
        test_random_settings();
        test_no_idle_stretch();
        test_zero_peaks();
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
